@@ src/tas_pkg.sv @@
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants of the tile animation sequencer: request kinds,
// arithmetic unit operations, and the request and result records.
// ----------------------------------------------------------------------------
package tas_pkg;

   // Field widths fixed by the interface
   localparam int TILE_W  = 8;
   localparam int DUR_W   = 16;
   localparam int EL_W    = 17;
   localparam int DUR_MAX = 65535;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Operations of the shared add/subtract unit
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // One request as handed to the sequencer
   typedef struct packed {
      kind_type             kind;
      logic [TILE_W-1:0]    tile_id;
      logic [TILE_W-1:0]    frame_tile;
      logic [DUR_W-1:0]     frame_duration;
      logic [DUR_W-1:0]     delta_time;
   } req_type;

   // One result
   typedef struct packed {
      logic                 status;
      logic [TILE_W-1:0]    shown_tile;
      logic                 animated;
   } rsp_type;

endpackage

@@ src/tas_alu.sv @@
// ----------------------------------------------------------------------------
// tas_alu
// Shared add/subtract unit. On subtract, ge tells that a is not below b.
// ----------------------------------------------------------------------------
module tas_alu #(
   parameter int W = 18
) (
   input  logic [W-1:0]           a,
   input  logic [W-1:0]           b,
   input  tas_pkg::alu_op_type    op,
   output logic [W-1:0]           res,
   output logic                   ge
);

   logic [W:0]   sum;
   logic [W-1:0] b_opnd;
   logic         cin;

   // Invert b and add one to subtract; carry out means no borrow
   always_comb begin
      cin    = (op == tas_pkg::ALU_SUB);
      b_opnd = (op == tas_pkg::ALU_SUB) ? ~b : b;
      sum    = {1'b0, a} + {1'b0, b_opnd} + {{W{1'b0}}, cin};
      res    = sum[W-1:0];
      ge     = sum[W];
   end

endmodule

@@ src/tas_ctrl.sv @@
// ----------------------------------------------------------------------------
// tas_ctrl
// Sequencer of the tile animation block. Holds the frame store and the
// per-tile state store and drives the shared add/subtract unit through
// ticks, appends, queries and clears.
// ----------------------------------------------------------------------------
module tas_ctrl #(
   parameter int NUM_TILES  = 256,
   parameter int MAX_FRAMES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tas_pkg::req_type   req,
   output logic               ready,
   output logic               done,
   input  logic               ack,
   output tas_pkg::rsp_type   res
);

   localparam int EL_W   = tas_pkg::EL_W;
   localparam int DUR_W  = tas_pkg::DUR_W;
   localparam int TILE_W = tas_pkg::TILE_W;
   localparam int TW     = $clog2(NUM_TILES);
   localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW     = $clog2(MAX_FRAMES + 1);
   localparam int FDEPTH = NUM_TILES * MAX_FRAMES;
   localparam int FAW    = $clog2(FDEPTH);
   localparam int TOTW   = $clog2(MAX_FRAMES * tas_pkg::DUR_MAX + 1);
   localparam int AW     = ((TOTW > EL_W) ? TOTW : EL_W) + 1;
   localparam int SWD    = CW + FW + EL_W;
   localparam int DCW    = $clog2(EL_W);
   localparam int FMW    = TILE_W + DUR_W;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_INIT   = 16'h0002,
      ST_CLR    = 16'h0004,
      ST_TREAD  = 16'h0008,
      ST_TLOAD  = 16'h0010,
      ST_SUM    = 16'h0020,
      ST_CMP    = 16'h0040,
      ST_DIV    = 16'h0080,
      ST_STEP   = 16'h0100,
      ST_AREAD  = 16'h0200,
      ST_AWR    = 16'h0400,
      ST_QREAD  = 16'h0800,
      ST_QLOAD  = 16'h1000,
      ST_QFRAME = 16'h2000,
      ST_RESP   = 16'h4000,
      ST_SPARE  = 16'h8000
   } state_type;

   state_type            state_ff, state_in;
   logic [TW-1:0]        tidx_ff, tidx_in;
   logic [FAW-1:0]       base_ff, base_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [FW-1:0]        cur_ff, cur_in;
   logic [FW-1:0]        f_ff, f_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [AW-1:0]        total_ff, total_in;
   logic [AW-1:0]        rem_ff, rem_in;
   logic [EL_W-1:0]      dv_ff, dv_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic [TILE_W-1:0]    ftile_ff, ftile_in;
   logic [DUR_W-1:0]     fdur_ff, fdur_in;
   logic [DUR_W-1:0]     dt_ff, dt_in;
   tas_pkg::rsp_type     res_ff, res_in;

   // Frame store: {shown tile, duration}
   logic [FMW-1:0]       fmem [FDEPTH];
   logic                 fm_we;
   logic [FAW-1:0]       fm_waddr;
   logic [FAW-1:0]       fm_raddr;
   logic [FMW-1:0]       fm_rdata_ff;
   logic [FW-1:0]        fr_idx;
   logic [DUR_W-1:0]     fr_dur;
   logic [TILE_W-1:0]    fr_tile;

   // Tile state store: {frame count, current frame, elapsed}
   logic [SWD-1:0]       smem [NUM_TILES];
   logic                 sm_we;
   logic [SWD-1:0]       sm_wdata;
   logic [SWD-1:0]       sm_rdata_ff;
   logic [CW-1:0]        st_cnt;
   logic [FW-1:0]        st_cur;
   logic [FW-1:0]        st_cur_ok;
   logic [EL_W-1:0]      st_el;

   // Shared unit
   logic [AW-1:0]        alu_a, alu_b, alu_res;
   tas_pkg::alu_op_type  alu_op;
   logic                 alu_ge;

   logic [AW-1:0]        rem_sh, rem_new;
   logic [CW-1:0]        cur_inc;
   logic [FW-1:0]        cur_nx;
   logic                 last_tile;
   logic                 in_range;

   tas_alu #(.W(AW)) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .op  (alu_op),
      .res (alu_res),
      .ge  (alu_ge)
   );

   // Decode stored words
   always_comb begin
      st_cnt    = sm_rdata_ff[SWD-1 -: CW];
      st_cur    = sm_rdata_ff[EL_W +: FW];
      st_el     = sm_rdata_ff[EL_W-1:0];
      st_cur_ok = (CW'(st_cur) < st_cnt) ? st_cur : '0;
      fr_dur    = fm_rdata_ff[DUR_W-1:0];
      fr_tile   = fm_rdata_ff[FMW-1 -: TILE_W];
      rem_sh    = {rem_ff[AW-2:0], dv_ff[EL_W-1]};
      rem_new   = alu_ge ? alu_res : rem_sh;
      cur_inc   = CW'(cur_ff) + CW'(1);
      cur_nx    = (cur_inc >= cnt_ff) ? '0 : cur_inc[FW-1:0];
      last_tile = (tidx_ff == TW'(NUM_TILES - 1));
      in_range  = (32'(req.tile_id) < NUM_TILES);
   end

   // Steer the shared unit
   always_comb begin
      alu_a  = acc_ff;
      alu_b  = total_ff;
      alu_op = tas_pkg::ALU_SUB;
      unique case (state_ff)
         ST_TLOAD: begin
            alu_a  = AW'(st_el);
            alu_b  = AW'(dt_ff);
            alu_op = tas_pkg::ALU_ADD;
         end
         ST_SUM: begin
            alu_a  = total_ff;
            alu_b  = AW'(fr_dur);
            alu_op = tas_pkg::ALU_ADD;
         end
         ST_DIV: begin
            alu_a = rem_sh;
         end
         ST_STEP: begin
            alu_b = AW'(fr_dur);
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
   end

   // Pick the frame to read next
   always_comb begin
      unique case (state_ff)
         ST_TLOAD: fr_idx = '0;
         ST_SUM:   fr_idx = f_ff + FW'(1);
         ST_QLOAD: fr_idx = st_cur_ok;
         ST_STEP:  fr_idx = alu_ge ? cur_nx : cur_ff;
         default:  fr_idx = cur_ff;
      endcase
      fm_raddr = base_ff + FAW'(fr_idx);
      fm_waddr = base_ff + FAW'(st_cnt);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      tidx_in  = tidx_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      f_in     = f_ff;
      acc_in   = acc_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      dcnt_in  = dcnt_ff;
      ftile_in = ftile_ff;
      fdur_in  = fdur_ff;
      dt_in    = dt_ff;
      res_in   = res_ff;
      fm_we    = 1'b0;
      sm_we    = 1'b0;
      sm_wdata = '0;
      unique case (state_ff)
         // Sweep the tile state store after reset
         ST_INIT: begin
            sm_we   = 1'b1;
            tidx_in = tidx_ff + TW'(1);
            if (last_tile) begin
               state_in = ST_IDLE;
            end
         end
         // Take a request and dispatch on its kind
         ST_IDLE: begin
            if (start) begin
               ftile_in = req.frame_tile;
               fdur_in  = (req.frame_duration == '0) ? DUR_W'(1) : req.frame_duration;
               dt_in    = req.delta_time;
               res_in   = '0;
               tidx_in  = TW'(req.tile_id);
               unique case (req.kind)
                  tas_pkg::KIND_TICK: begin
                     tidx_in  = '0;
                     state_in = ST_TREAD;
                  end
                  tas_pkg::KIND_APPEND: begin
                     if (in_range) begin
                        state_in = ST_AREAD;
                     end else begin
                        res_in.status = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  tas_pkg::KIND_QUERY: begin
                     res_in.shown_tile = req.tile_id;
                     state_in = in_range ? ST_QREAD : ST_RESP;
                  end
                  tas_pkg::KIND_CLEAR: begin
                     tidx_in  = '0;
                     state_in = ST_CLR;
                  end
               endcase
            end
         end
         // Zero every tile's state
         ST_CLR: begin
            sm_we   = 1'b1;
            tidx_in = tidx_ff + TW'(1);
            if (last_tile) begin
               state_in = ST_RESP;
            end
         end
         // Read the tile's state and locate its frames
         ST_TREAD: begin
            base_in  = FAW'(tidx_ff) * FAW'(MAX_FRAMES);
            state_in = ST_TLOAD;
         end
         // Add the elapsed time; skip tiles without frames
         ST_TLOAD: begin
            cnt_in   = st_cnt;
            cur_in   = st_cur_ok;
            acc_in   = alu_res;
            total_in = '0;
            f_in     = '0;
            if (st_cnt == '0) begin
               tidx_in  = tidx_ff + TW'(1);
               state_in = last_tile ? ST_RESP : ST_TREAD;
            end else begin
               state_in = ST_SUM;
            end
         end
         // Sum the durations of the frame list
         ST_SUM: begin
            total_in = alu_res;
            f_in     = f_ff + FW'(1);
            if (CW'(f_ff) + CW'(1) == cnt_ff) begin
               state_in = ST_CMP;
            end
         end
         // Remove whole passes through the list if time covers one
         ST_CMP: begin
            if (alu_ge) begin
               rem_in   = '0;
               dv_in    = acc_ff[EL_W-1:0];
               dcnt_in  = '0;
               state_in = ST_DIV;
            end else begin
               state_in = ST_STEP;
            end
         end
         // Restoring remainder, one bit per cycle
         ST_DIV: begin
            rem_in  = rem_new;
            dv_in   = {dv_ff[EL_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(EL_W - 1)) begin
               acc_in   = rem_new;
               state_in = ST_STEP;
            end
         end
         // Advance frames while the current duration fits; then write back
         ST_STEP: begin
            if (alu_ge) begin
               acc_in = alu_res;
               cur_in = cur_nx;
            end else begin
               sm_we    = 1'b1;
               sm_wdata = {cnt_ff, cur_ff, acc_ff[EL_W-1:0]};
               tidx_in  = tidx_ff + TW'(1);
               state_in = last_tile ? ST_RESP : ST_TREAD;
            end
         end
         ST_AREAD: begin
            base_in  = FAW'(tidx_ff) * FAW'(MAX_FRAMES);
            state_in = ST_AWR;
         end
         // Store the frame unless the list is full
         ST_AWR: begin
            if (st_cnt >= CW'(MAX_FRAMES)) begin
               res_in.status = 1'b1;
            end else begin
               fm_we    = 1'b1;
               sm_we    = 1'b1;
               sm_wdata = {st_cnt + CW'(1), st_cur, st_el};
            end
            state_in = ST_RESP;
         end
         ST_QREAD: begin
            base_in  = FAW'(tidx_ff) * FAW'(MAX_FRAMES);
            state_in = ST_QLOAD;
         end
         ST_QLOAD: begin
            state_in = (st_cnt == '0) ? ST_RESP : ST_QFRAME;
         end
         ST_QFRAME: begin
            res_in.shown_tile = fr_tile;
            res_in.animated   = 1'b1;
            state_in          = ST_RESP;
         end
         // Hold the result until the output stage takes it
         ST_RESP: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         tidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tidx_ff  <= tidx_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      cur_ff   <= cur_in;
      f_ff     <= f_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      dv_ff    <= dv_in;
      dcnt_ff  <= dcnt_in;
      ftile_ff <= ftile_in;
      fdur_ff  <= fdur_in;
      dt_ff    <= dt_in;
      res_ff   <= res_in;
   end

   // Frame store
   always_ff @(posedge clock) begin
      if (fm_we) begin
         fmem[fm_waddr] <= {ftile_ff, fdur_ff};
      end
      fm_rdata_ff <= fmem[fm_raddr];
   end

   // Tile state store
   always_ff @(posedge clock) begin
      if (sm_we) begin
         smem[tidx_ff] <= sm_wdata;
      end
      sm_rdata_ff <= smem[tidx_ff];
   end

   assign ready = (state_ff == ST_IDLE);
   assign done  = (state_ff == ST_RESP);
   assign res   = res_ff;

   // A frame is written only into a list with room left
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      fm_we |-> (st_cnt < CW'(MAX_FRAMES)))
      else $error("frame written into a full list");

   // Stepping always works on a frame inside the list
   a_step_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (CW'(cur_ff) < cnt_ff))
      else $error("current frame beyond frame count");

   // The remainder never runs against an empty list total
   a_div_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (total_ff != '0))
      else $error("remainder by zero total");

   // Time left on a tile is below one frame duration at write back
   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && !alu_ge) |-> (acc_ff[AW-1:DUR_W] == '0))
      else $error("elapsed time left exceeds a frame duration");

   // New requests arrive only while idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> ready)
      else $error("request started while busy");

endmodule

@@ src/tile_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// tile_animation_sequencer
// Keeps per-tile frame lists and steps them on ticks. One request is worked
// at a time by a sequencer around a single add/subtract unit; every request
// gives one result. A clear zeroes the state of all NUM_TILES tiles. A tick
// walks all NUM_TILES tiles; a tile without frames is skipped, while an
// animated tile with n frames has its durations summed and then advances
// by at most n - 1 frames, after a bit-serial remainder when the elapsed
// time covers a whole pass through its list. After reset the tile state
// store is cleared in a pass over all tiles during which no request is
// taken. The result sits in an output register, so a new request is taken
// while an earlier result still waits to be read.
// ----------------------------------------------------------------------------
module tile_animation_sequencer #(
   parameter int NUM_TILES  = 256,
   parameter int MAX_FRAMES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_kind,
   input  logic [7:0]   req_tile_id,
   input  logic [7:0]   req_frame_tile,
   input  logic [15:0]  req_frame_duration,
   input  logic [15:0]  req_delta_time,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_status,
   output logic [7:0]   rsp_shown_tile,
   output logic         rsp_animated
);

   tas_pkg::req_type   req;
   tas_pkg::rsp_type   res;
   tas_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               ctrl_ready;
   logic               ctrl_done;
   logic               start;
   logic               ack;

   // Gather the request fields
   always_comb begin
      req.kind           = tas_pkg::kind_type'(req_kind);
      req.tile_id        = req_tile_id;
      req.frame_tile     = req_frame_tile;
      req.frame_duration = req_frame_duration;
      req.delta_time     = req_delta_time;
   end

   assign req_stall = !ctrl_ready;
   assign start     = req_valid && ctrl_ready;

   tas_ctrl #(
      .NUM_TILES  (NUM_TILES),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req),
      .ready (ctrl_ready),
      .done  (ctrl_done),
      .ack   (ack),
      .res   (res)
   );

   // Load the output register when it is empty or being drained
   always_comb begin
      ack          = ctrl_done && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = ack || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = ack ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_shown_tile = rsp_data_ff.shown_tile;
   assign rsp_animated   = rsp_data_ff.animated;

endmodule
